/* design/thf_pkg.sv */
// ----------------------------------------------------------------------------
// Threshold hit finder package
// Shared widths, register indexes and the command and status types that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package thf_pkg;

    // Field widths
    localparam int CHAN_W   = 20;
    localparam int SAMPLE_W = 16;
    localparam int START_W  = 20;
    localparam int CHARGE_W = 36;
    localparam int QUOT_W   = 35;
    localparam int DUR_W    = 21;

    // Configuration register widths
    localparam int THR_W = 15;
    localparam int DS_W  = 5;
    localparam int DIV_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNSAMPLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_DIV   = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd200;
    localparam logic [DS_W-1:0]  DOWNSAMPLE_RST = 5'd1;
    localparam logic [DIV_W-1:0] CHARGE_DIV_RST = 16'd99;

    // Samples per waveform before the sample index wraps
    localparam int MAX_WAVEFORM_SAMPLES = 65536;
    localparam int IDX_W = $clog2(MAX_WAVEFORM_SAMPLES);

    // Width of the start tick product before saturation
    localparam int STP_W = (IDX_W + DS_W > START_W) ? IDX_W + DS_W : START_W;

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = ((CHAN_W + SAMPLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CHAN_W + START_W + QUOT_W + DUR_W + 7) / 8) * 8;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = CHARGE_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic div_load;  // load the divider with the closing hit's charge
        logic div_step;  // one restoring division step
        logic out_load;  // move the finished hit into the output register
    } thf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit;      // the offered sample closes an open hit
    } thf_status_t;

endpackage

/* design/thf_div.sv */
// ----------------------------------------------------------------------------
// Threshold hit finder divider
// Restoring divider that produces one quotient bit per step and saturates
// the quotient to the width of the emitted charge.
// ----------------------------------------------------------------------------
module thf_div (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [thf_pkg::CHARGE_W-1:0]  dividend,
    input  logic [thf_pkg::DIV_W-1:0]     divisor,
    output logic [thf_pkg::QUOT_W-1:0]    quotient
);
    import thf_pkg::*;

    logic [CHARGE_W-1:0] quot_reg;
    logic [CHARGE_W-1:0] quot_next;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    rem_next;
    logic [DIV_W-1:0]    dvsr_reg;
    logic [DIV_W-1:0]    dvsr_next;
    logic [DIV_W:0]      trial;
    logic                fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial     = {rem_reg, quot_reg[CHARGE_W-1]};
        fits      = (trial >= {1'b0, dvsr_reg});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (load)
        begin
            quot_next = dividend;
            rem_next  = '0;
            // A zero divisor behaves as one.
            dvsr_next = (divisor == '0) ? DIV_W'(1) : divisor;
        end
        else if (step)
        begin
            quot_next = {quot_reg[CHARGE_W-2:0], fits};
            rem_next  = fits ? DIV_W'(trial - {1'b0, dvsr_reg}) : trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    // Saturate to the emitted charge width.
    assign quotient = quot_reg[CHARGE_W-1] ? {QUOT_W{1'b1}} : quot_reg[QUOT_W-1:0];

endmodule

/* design/thf_ctrl.sv */
// ----------------------------------------------------------------------------
// Threshold hit finder controller
// Sequences input acceptance, the charge division of a closing hit and the
// hand-off of the finished hit to the output register.
// ----------------------------------------------------------------------------
module thf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  thf_pkg::thf_status_t  status,
    output thf_pkg::thf_cmd_t     cmd
);
    import thf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.emit)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* design/thf_dp.sv */
// ----------------------------------------------------------------------------
// Threshold hit finder datapath
// Configuration registers, per-channel hit state, the hit record held during
// division, the divider and the output payload register.
// ----------------------------------------------------------------------------
module thf_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [thf_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                             s_tlast,
    output logic [thf_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [thf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [thf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  thf_pkg::thf_cmd_t                cmd,
    output thf_pkg::thf_status_t             status
);
    import thf_pkg::*;

    localparam logic [START_W-1:0]  START_MAX = {START_W{1'b1}};
    localparam logic [CHARGE_W-1:0] SUM_MAX   = {CHARGE_W{1'b1}};
    localparam logic [DUR_W-1:0]    DUR_MAX   = {DUR_W{1'b1}};

    // Configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [DS_W-1:0]  ds_reg;
    logic [DIV_W-1:0] cdiv_reg;

    // Per-channel state
    logic                in_hit_reg,  in_hit_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [START_W-1:0]  start_reg,   start_next;
    logic [CHARGE_W-1:0] charge_reg,  charge_next;
    logic [DUR_W-1:0]    dur_reg,     dur_next;
    logic [CHAN_W-1:0]   chan_reg,    chan_next;

    // Hit record held while the charge is divided
    logic [CHAN_W-1:0]   hold_chan_reg;
    logic [START_W-1:0]  hold_start_reg;
    logic [DUR_W-1:0]    hold_dur_reg;

    // Output payload
    logic [M_DATA_W-1:0] out_data_reg;

    // Item decode
    logic [CHAN_W-1:0]   in_chan;
    logic [SAMPLE_W-1:0] in_sample;
    logic                changed;
    logic                over;
    logic                e_in_hit;
    logic [IDX_W-1:0]    e_idx;
    logic [CHARGE_W-1:0] e_charge;
    logic [DUR_W-1:0]    e_dur;
    logic [STP_W-1:0]    start_prod;
    logic [SAMPLE_W+DS_W-1:0] add_prod;
    logic [CHARGE_W:0]   charge_sum;
    logic [DUR_W:0]      dur_sum;
    logic [QUOT_W-1:0]   quotient;

    assign cfg_ready = 1'b1;

    // Configuration writes; an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            ds_reg   <= DOWNSAMPLE_RST;
            cdiv_reg <= CHARGE_DIV_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_reg  <= cfg_data[THR_W-1:0];
                REG_DOWNSAMPLE: ds_reg   <= cfg_data[DS_W-1:0];
                REG_CHARGE_DIV: cdiv_reg <= cfg_data[DIV_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sample decode against the channel state; a new channel starts clean.
    always_comb
    begin
        in_chan    = s_tdata[CHAN_W-1:0];
        in_sample  = s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
        changed    = (in_chan != chan_reg);
        e_in_hit   = changed ? 1'b0 : in_hit_reg;
        e_idx      = changed ? '0 : idx_reg;
        e_charge   = changed ? '0 : charge_reg;
        e_dur      = changed ? '0 : dur_reg;
        over       = ($signed(in_sample) > $signed({1'b0, thr_reg}));
        start_prod = STP_W'(e_idx) * STP_W'(ds_reg);
        add_prod   = (SAMPLE_W+DS_W)'(in_sample) * (SAMPLE_W+DS_W)'(ds_reg);
        charge_sum = {1'b0, e_charge} + (CHARGE_W+1)'(add_prod);
        dur_sum    = {1'b0, e_dur} + (DUR_W+1)'(ds_reg);
        status.emit = !s_tlast && !over && e_in_hit;
    end

    // Per-channel state update for an accepted sample
    always_comb
    begin
        in_hit_next = in_hit_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        charge_next = charge_reg;
        dur_next    = dur_reg;
        chan_next   = chan_reg;
        if (cmd.accept)
        begin
            chan_next = in_chan;
            if (s_tlast)
            begin
                in_hit_next = 1'b0;
                idx_next    = '0;
                start_next  = '0;
                charge_next = '0;
                dur_next    = '0;
            end
            else
            begin
                in_hit_next = e_in_hit;
                start_next  = changed ? '0 : start_reg;
                charge_next = e_charge;
                dur_next    = e_dur;
                if (over && !e_in_hit)
                begin
                    // Opening sample of a hit
                    in_hit_next = 1'b1;
                    start_next  = (start_prod > STP_W'(START_MAX)) ? START_MAX
                                                                   : start_prod[START_W-1:0];
                    charge_next = CHARGE_W'(in_sample);
                    dur_next    = DUR_W'(ds_reg);
                end
                else if (over)
                begin
                    // Hit continues; both sums saturate.
                    charge_next = charge_sum[CHARGE_W] ? SUM_MAX : charge_sum[CHARGE_W-1:0];
                    dur_next    = dur_sum[DUR_W] ? DUR_MAX : dur_sum[DUR_W-1:0];
                end
                else if (e_in_hit)
                begin
                    // Hit closes; its record moves to the hold registers.
                    in_hit_next = 1'b0;
                    start_next  = '0;
                    charge_next = '0;
                    dur_next    = '0;
                end
                idx_next = (e_idx == IDX_W'(MAX_WAVEFORM_SAMPLES - 1)) ? '0
                                                                       : e_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hit_reg <= 1'b0;
            idx_reg    <= '0;
            start_reg  <= '0;
            charge_reg <= '0;
            dur_reg    <= '0;
            chan_reg   <= '0;
        end
        else
        begin
            in_hit_reg <= in_hit_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            charge_reg <= charge_next;
            dur_reg    <= dur_next;
            chan_reg   <= chan_next;
        end
    end

    // Hit record capture and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            hold_chan_reg  <= in_chan;
            hold_start_reg <= start_reg;
            hold_dur_reg   <= dur_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= M_DATA_W'({hold_dur_reg, quotient, hold_start_reg, hold_chan_reg});
        end
    end

    // Charge divider
    thf_div u_div (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (charge_reg),
        .divisor  (cdiv_reg),
        .quotient (quotient)
    );

    assign m_tdata = out_data_reg;

endmodule

/* design/threshold_hit_finder_core.sv */
// ----------------------------------------------------------------------------
// Threshold hit finder core
// Time-over-threshold hit finder on a stream of channel waveform samples.
//
//  Channel   Direction  Handshake              Content
//  s_*       in         s_tvalid / s_tready    channel id and sample, tlast ends channel
//  m_*       out        m_tvalid / m_tready    one finished hit per transaction
//  cfg_*     in         cfg_valid / cfg_ready  register index and write data
//
// A sample that closes a hit holds off the input while its charge goes through
// the serial restoring divider one quotient bit per cycle, and the hit then
// moves into the output register. While a finished hit waits in the output
// register the next samples are still taken; only another closing hit waits
// for it. Reset is asynchronous and active low and restores the register
// defaults.
// ----------------------------------------------------------------------------
module threshold_hit_finder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [thf_pkg::S_DATA_W-1:0]    s_tdata,   // channel_id[19:0], sample[35:20]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [thf_pkg::M_DATA_W-1:0]    m_tdata,   // hit_channel[19:0], start_time[39:20],
                                                       // hit_charge[74:40],
                                                       // time_over_threshold[95:75]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [thf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [thf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import thf_pkg::*;

    thf_cmd_t    cmd;
    thf_status_t status;

    // Sequencer
    thf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hit state, divider and output payload
    thf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* sim/tb_threshold_hit_finder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold hit finder core testbench
// Streams channel waveforms into the core and checks every emitted hit
// against a cycle-free prediction of the hit finder. The predictor runs as
// each sample transaction is accepted. The checker compares each hit
// transaction with the oldest predicted hit, field by field. Stimulus covers
// directed corner cases, register extremes, back-to-back traffic, a long
// output stall and random channel runs.
// ----------------------------------------------------------------------------
module tb_threshold_hit_finder_core;

    import thf_pkg::*;

    // Write to an index past the register list; the core must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Cycles to let a closing sample finish after the last hit has arrived
    localparam int SETTLE_CYCLES = DIV_STEPS + 8;

    localparam logic [START_W-1:0]  START_SAT  = '1;
    localparam logic [DUR_W-1:0]    DUR_SAT    = '1;
    localparam logic [CHARGE_W-1:0] CHARGE_SAT = '1;
    localparam logic [QUOT_W-1:0]   QUOT_SAT   = '1;

    // One hit as it travels on m_tdata, last field in the lowest bits
    typedef struct packed {
        logic [DUR_W-1:0]   tot;
        logic [QUOT_W-1:0]  charge;
        logic [START_W-1:0] start_tick;
        logic [CHAN_W-1:0]  channel;
    } hit_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;   // channel_id[19:0], sample[35:20]
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;        // hit_channel[19:0], start_time[39:20],
                                            // hit_charge[74:40],
                                            // time_over_threshold[95:75]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the registers and of the per-channel state
    logic [THR_W-1:0]    cfg_thr = THRESHOLD_RST;
    logic [DS_W-1:0]     cfg_ds = DOWNSAMPLE_RST;
    logic [DIV_W-1:0]    cfg_div = CHARGE_DIV_RST;
    logic [CHAN_W-1:0]   cur_chan = '0;
    bit                  in_pulse = 1'b0;
    logic [IDX_W-1:0]    samp_idx = '0;
    logic [START_W-1:0]  pulse_start = '0;
    logic [CHARGE_W-1:0] charge_acc = '0;
    logic [DUR_W-1:0]    pulse_len = '0;

    hit_t pending_hits[$];
    int   error_count = 0;
    bit   idle_on = 1'b1;
    int   rx_hold_cycles = 0;
    int   samples_sent = 0;

    threshold_hit_finder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always #1 clk = ~clk;

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
            report_error($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    function automatic void clear_channel_state();
        in_pulse    = 1'b0;
        samp_idx    = '0;
        pulse_start = '0;
        charge_acc  = '0;
        pulse_len   = '0;
    endfunction

    // Hit finder prediction for one accepted sample transaction.
    function automatic void model_sample(input logic [CHAN_W-1:0] chan,
                                         input logic [SAMPLE_W-1:0] smp, input bit last);
        longint unsigned acc;
        longint unsigned quot;
        hit_t            hit;
        if (chan != cur_chan) begin
            clear_channel_state();
            cur_chan = chan;
        end
        if (last) begin
            clear_channel_state();
            return;
        end
        if ($signed(smp) > $signed({1'b0, cfg_thr})) begin
            if (!in_pulse) begin
                // First sample over threshold opens the hit.
                acc = 64'(samp_idx);
                acc = acc * 64'(cfg_ds);
                pulse_start = (acc > 64'(START_SAT)) ? START_SAT : acc[START_W-1:0];
                charge_acc  = CHARGE_W'(smp[SAMPLE_W-2:0]);
                pulse_len   = DUR_W'(cfg_ds);
                in_pulse    = 1'b1;
            end else begin
                // Further samples add scaled charge and ticks, saturating.
                acc = 64'(smp[SAMPLE_W-2:0]);
                acc = acc * 64'(cfg_ds) + 64'(charge_acc);
                charge_acc = (acc > 64'(CHARGE_SAT)) ? CHARGE_SAT : acc[CHARGE_W-1:0];
                acc = 64'(pulse_len);
                acc = acc + 64'(cfg_ds);
                pulse_len = (acc > 64'(DUR_SAT)) ? DUR_SAT : acc[DUR_W-1:0];
            end
        end else if (in_pulse) begin
            // Falling to or below threshold closes the hit.
            acc  = (cfg_div == '0) ? 64'd1 : 64'(cfg_div);
            quot = 64'(charge_acc) / acc;
            hit.channel    = cur_chan;
            hit.start_tick = pulse_start;
            hit.charge     = (quot > 64'(QUOT_SAT)) ? QUOT_SAT : quot[QUOT_W-1:0];
            hit.tot        = pulse_len;
            pending_hits   = {pending_hits, hit};
            in_pulse    = 1'b0;
            pulse_start = '0;
            charge_acc  = '0;
            pulse_len   = '0;
        end
        samp_idx = samp_idx + IDX_W'(1);
    endfunction

    // Hit checker and receiver readiness.
    always @(posedge clk) begin : hit_checker
        hit_t got;
        hit_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_hits.size() == 0) begin
                report_error($sformatf("unexpected hit ch=%0h start=%0h q=%0h tot=%0h",
                             got.channel, got.start_tick, got.charge, got.tot));
            end else begin
                want = pending_hits.pop_front();
                check_field("hit_channel", 64'(want.channel), 64'(got.channel));
                check_field("start_time", 64'(want.start_tick), 64'(got.start_tick));
                check_field("hit_charge", 64'(want.charge), 64'(got.charge));
                check_field("time_over_threshold", 64'(want.tot), 64'(got.tot));
            end
        end
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= 15);
        end
    end

    // Offer one sample and wait for its transaction; valid stays high after.
    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_W-1:0] smp, input bit last);
        while (idle_on && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - CHAN_W - SAMPLE_W){1'b0}}, smp, chan};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        model_sample(chan, smp, last);
        samples_sent++;
    endtask

    // Stop offering samples and let every pending hit come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_THRESHOLD:  cfg_thr = data[THR_W-1:0];
            REG_DOWNSAMPLE: cfg_ds  = data[DS_W-1:0];
            REG_CHARGE_DIV: cfg_div = data[DIV_W-1:0];
            default: ;
        endcase
    endtask

    // Write all registers while the core is idle; unused bits get random values.
    task automatic apply_config(input logic [THR_W-1:0] thr, input logic [DS_W-1:0] ds,
                                input logic [DIV_W-1:0] div);
        logic [CFG_DATA_W-1:0] word;
        drain();
        word = CFG_DATA_W'($urandom);
        word[THR_W-1:0] = thr;
        write_reg(REG_THRESHOLD, word);
        word = CFG_DATA_W'($urandom);
        word[DS_W-1:0] = ds;
        write_reg(REG_DOWNSAMPLE, word);
        write_reg(REG_CHARGE_DIV, div);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // One channel waveform: baseline with random pulses above threshold.
    task automatic send_run(input logic [CHAN_W-1:0] chan, input int len, input bit with_last);
        bit high;
        int v;
        high = 1'b0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < (high ? 35 : 25))
                high = !high;
            if (high && cfg_thr != {THR_W{1'b1}})
                v = int'($urandom_range(int'(cfg_thr) + 1, 32767));
            else
                v = int'($urandom_range(0, int'(cfg_thr) + 32768)) - 32768;
            send_sample(chan, v[SAMPLE_W-1:0], with_last && (i == len - 1));
        end
    endtask

    // Register defaults and the corner cases of a waveform.
    task automatic test_reset_defaults();
        send_sample(20'h00000, 16'd201, 1'b0);
        send_sample(20'h00000, 16'd200, 1'b0);
        send_sample(20'h00000, 16'h7FFF, 1'b0);
        send_sample(20'h00000, 16'h7FFF, 1'b0);
        send_sample(20'h00000, 16'h8000, 1'b0);
        send_sample(20'h00000, 16'h8000, 1'b0);
        // Open hit dropped by the last sample of the channel.
        send_sample(20'h00000, 16'd500, 1'b0);
        send_sample(20'h00000, 16'd0, 1'b1);
        // Open hit dropped by a change of channel.
        send_sample(20'h00005, 16'd1000, 1'b0);
        send_sample(20'hFFFFF, 16'd1000, 1'b0);
        send_sample(20'hFFFFF, 16'd1000, 1'b0);
        send_sample(20'hFFFFF, 16'd0, 1'b0);
        // A flagged sample is never examined, even above threshold.
        send_sample(20'h00007, 16'h7FFF, 1'b1);
        send_sample(20'h00007, 16'h5555, 1'b0);
        send_sample(20'h00007, 16'hAAAA, 1'b0);
        send_sample(20'h00007, 16'd201, 1'b1);
        send_sample(20'h5A5A5, 16'd201, 1'b0);
        send_sample(20'h5A5A5, 16'hFFFF, 1'b0);
        send_sample(20'hA5A5A, 16'h7FFF, 1'b0);
        send_sample(20'hA5A5A, 16'd200, 1'b0);
    endtask

    // Extreme register settings, including a zero divisor and zero factor.
    task automatic test_register_extremes();
        apply_config(15'd0, 5'd0, 16'd0);
        repeat (3) send_run(CHAN_W'($urandom), 8, 1'b1);
        apply_config(15'h7FFF, 5'd31, 16'hFFFF);
        repeat (3) send_run(CHAN_W'($urandom), 8, 1'b1);
        apply_config(15'd0, 5'd31, 16'd1);
        repeat (3) send_run(CHAN_W'($urandom), 8, 1'b1);
        apply_config(15'd1000, 5'd16, 16'hFFFF);
        repeat (3) send_run(CHAN_W'($urandom), 8, 1'b1);
        apply_config(15'd100, 5'd1, 16'd0);
        repeat (3) send_run(CHAN_W'($urandom), 8, 1'b1);
    endtask

    // Full-rate traffic on both sides.
    task automatic test_back_to_back();
        apply_config(15'd300, 5'd2, 16'd7);
        idle_on = 1'b0;
        repeat (7) send_run(CHAN_W'($urandom_range(0, 3)), 12, $urandom_range(0, 1) != 0);
        drain();
        idle_on = 1'b1;
    endtask

    // Receiver holds off while hits keep closing, so the input must stall.
    task automatic test_output_stall();
        apply_config(15'd50, 5'd3, 16'd5);
        rx_hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_sample(20'h00011, (i % 2 == 0) ? 16'd4000 : 16'd10, 1'b0);
        send_sample(20'h00011, 16'd0, 1'b1);
    endtask

    // Random channel runs over several register settings, with some noise.
    task automatic test_random_runs();
        logic [CHAN_W-1:0] pool[4];
        logic [CHAN_W-1:0] chan;
        int                target;
        pool = '{20'h00000, 20'h00001, 20'hFFFFF, 20'h5A5A5};
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: apply_config(THR_W'($urandom_range(0, 3000)), DS_W'($urandom_range(1, 16)),
                                DIV_W'($urandom_range(1, 200)));
                3: apply_config(THR_W'($urandom_range(0, 200)), DS_W'($urandom_range(17, 31)),
                                DIV_W'($urandom_range(0, 3)));
                default: apply_config(THR_W'($urandom_range(0, 32767)),
                                      DS_W'($urandom_range(0, 31)), DIV_W'($urandom));
            endcase
            target = samples_sent + 65;
            while (samples_sent < target) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_sample(CHAN_W'($urandom), SAMPLE_W'($urandom),
                                $urandom_range(0, 1) != 0);
                end else begin
                    chan = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom)
                                                       : pool[2'($urandom_range(0, 3))];
                    send_run(chan, $urandom_range(2, 24), $urandom_range(0, 9) < 8);
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_back_to_back();
        test_output_stall();
        test_random_runs();
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run time limit.
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
